>>> src/tla_pkg.sv
// Package for the traffic light arbiter: direction indices, counter widths
// and configuration register addresses. No dependencies.
package tla_pkg;

  localparam int unsigned NumDirs  = 4;
  localparam int unsigned CntW     = 8;
  localparam int unsigned ArriveW  = 4;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam int unsigned DirNs = 0;
  localparam int unsigned DirSn = 1;
  localparam int unsigned DirWe = 2;
  localparam int unsigned DirEw = 3;

  localparam logic [PaddrW-1:0] AddrWaitLimit = 3'd0;
  localparam logic [PaddrW-1:0] AddrHoldTicks = 3'd4;

  localparam logic [CntW-1:0] WaitLimitRst = 8'd5;
  localparam logic [CntW-1:0] HoldTicksRst = 8'd3;
  localparam logic [CntW-1:0] CntMax       = 8'hFF;

  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [NumDirs-1:0] light_t;

endpackage

>>> src/traffic_light_arbiter_unit.sv
// Top level of the traffic light arbiter: queue, wait and hold state, the
// axis decision and a two-entry result buffer. Depends on tla_pkg.
//
// Usage: one input item is one tick carrying car arrivals for four
// directions (valid/stall handshake, accepted when in_valid_i is high and
// in_stall_o is low). Each item yields exactly one result item with the four
// light bits, presented on out_valid_o and taken when out_stall_i is low.
// The state update and the lights are computed from the registered state
// and the accepted arrivals and land at the accepting edge in the output
// register, or in the skid register while the output register holds a
// stalled item. Throughput is one item per cycle while in_stall_o is low.
// When the receiver stalls, the output register holds its item and one more
// item is taken into a skid register; in_stall_o rises only while the skid
// register is full, so input stall is a registered signal.
// Reset clears queues, wait counts, the hold counter, selects north-south
// green, empties the result buffer and loads wait_limit = 5, hold_ticks = 3.
// Configuration goes through the APB port: wait_limit at address 0,
// hold_ticks at address 4; write only while the block is idle.
module traffic_light_arbiter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tla_pkg::PaddrW-1:0] paddr,
  input  logic [tla_pkg::PdataW-1:0] pwdata,
  output logic [tla_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [3:0]                 arrive_north_south_i,
  input  logic [3:0]                 arrive_south_north_i,
  input  logic [3:0]                 arrive_west_east_i,
  input  logic [3:0]                 arrive_east_west_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       light_north_south_o,
  output logic                       light_south_north_o,
  output logic                       light_west_east_o,
  output logic                       light_east_west_o
);
  import tla_pkg::*;

  cnt_t   wait_limit_q, hold_ticks_q;
  cnt_t   queue_q [NumDirs];
  cnt_t   queue_d [NumDirs];
  cnt_t   wait_q  [NumDirs];
  cnt_t   wait_d  [NumDirs];
  cnt_t   hold_q, hold_d;
  logic   ewg_q, ewg_d;

  logic               out_valid_q, skid_valid_q;
  light_t             out_data_q, skid_data_q;

  logic [ArriveW-1:0] arrive [NumDirs];
  cnt_t               q_add  [NumDirs];
  logic [CntW:0]      q_sum  [NumDirs];
  cnt_t               w_mid  [NumDirs];
  logic [CntW:0]      ns_total, ew_total;
  logic               ewg_a, ewg_b;
  logic               sw_ns, sw_ew;
  logic               green, has_cars;
  light_t             light;
  logic               in_fire, out_fire, cfg_wr;

  assign arrive[DirNs] = arrive_north_south_i;
  assign arrive[DirSn] = arrive_south_north_i;
  assign arrive[DirWe] = arrive_west_east_i;
  assign arrive[DirEw] = arrive_east_west_i;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr)
      AddrWaitLimit: prdata = {{(PdataW-CntW){1'b0}}, wait_limit_q};
      AddrHoldTicks: prdata = {{(PdataW-CntW){1'b0}}, hold_ticks_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_limit_q <= WaitLimitRst;
      hold_ticks_q <= HoldTicksRst;
    end else if (cfg_wr) begin
      if (paddr == AddrWaitLimit) wait_limit_q <= pwdata[CntW-1:0];
      if (paddr == AddrHoldTicks) hold_ticks_q <= pwdata[CntW-1:0];
    end
  end

  // tick update
  always_comb begin
    for (int i = 0; i < NumDirs; i++) begin
      q_sum[i] = {1'b0, queue_q[i]} + {{(CntW+1-ArriveW){1'b0}}, arrive[i]};
      q_add[i] = q_sum[i][CntW] ? CntMax : q_sum[i][CntW-1:0];
      w_mid[i] = wait_q[i];
    end
    ns_total = {1'b0, q_add[DirNs]} + {1'b0, q_add[DirSn]};
    ew_total = {1'b0, q_add[DirWe]} + {1'b0, q_add[DirEw]};

    hold_d = hold_q;
    ewg_a  = ewg_q;
    ewg_b  = ewg_q;
    ewg_d  = ewg_q;
    sw_ns  = 1'b0;
    sw_ew  = 1'b0;
    if (hold_q != '0) begin
      hold_d = hold_q - cnt_t'(1);
    end else begin
      ewg_a = ewg_q || (ns_total < ew_total);
      sw_ns = ewg_a && (wait_q[DirNs] > wait_limit_q || wait_q[DirSn] > wait_limit_q);
      ewg_b = sw_ns ? 1'b0 : ewg_a;
      sw_ew = !ewg_b && (wait_q[DirWe] > wait_limit_q || wait_q[DirEw] > wait_limit_q);
      ewg_d = sw_ew ? 1'b1 : ewg_b;
      if (sw_ns || sw_ew) hold_d = hold_ticks_q;
      if (sw_ns) begin
        w_mid[DirNs] = '0;
        w_mid[DirSn] = '0;
      end
      if (sw_ew) begin
        w_mid[DirWe] = '0;
        w_mid[DirEw] = '0;
      end
    end

    for (int i = 0; i < NumDirs; i++) begin
      green    = ((i == DirWe) || (i == DirEw)) == ewg_d;
      has_cars = q_add[i] != '0;
      light[i] = green && has_cars;
      wait_d[i] = w_mid[i];
      if (!green && has_cars && w_mid[i] != CntMax) wait_d[i] = w_mid[i] + cnt_t'(1);
      queue_d[i] = q_add[i] - {{(CntW-1){1'b0}}, light[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDirs; i++) begin
        queue_q[i] <= '0;
        wait_q[i]  <= '0;
      end
      hold_q <= '0;
      ewg_q  <= 1'b0;
    end else if (in_fire) begin
      queue_q <= queue_d;
      wait_q  <= wait_d;
      hold_q  <= hold_d;
      ewg_q   <= ewg_d;
    end
  end

  // result buffer: output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (in_fire) begin
        out_data_q <= light;
      end
    end else if (in_fire) begin
      skid_data_q <= light;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign light_north_south_o = out_data_q[DirNs];
  assign light_south_north_o = out_data_q[DirSn];
  assign light_west_east_o   = out_data_q[DirWe];
  assign light_east_west_o   = out_data_q[DirEw];

endmodule

>>> verif/traffic_light_arbiter_unit_tb.sv
// Testbench for traffic_light_arbiter_unit: drives arrival ticks, predicts the lights
// from its own model of the queues, waits and hold counter, and checks every light item.
// Depends on tla_pkg and the RTL under src.
module traffic_light_arbiter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tla_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumChunks  = 9;

  typedef struct packed {
    logic [ArriveW-1:0] ns;
    logic [ArriveW-1:0] sn;
    logic [ArriveW-1:0] we;
    logic [ArriveW-1:0] ew;
  } arrivals_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ArriveW-1:0] arrive_north_south_i = '0;
  logic [ArriveW-1:0] arrive_south_north_i = '0;
  logic [ArriveW-1:0] arrive_west_east_i = '0;
  logic [ArriveW-1:0] arrive_east_west_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic light_north_south_o;
  logic light_south_north_o;
  logic light_west_east_o;
  logic light_east_west_o;

  traffic_light_arbiter_unit i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .arrive_north_south_i,
    .arrive_south_north_i,
    .arrive_west_east_i,
    .arrive_east_west_i,
    .out_valid_o,
    .out_stall_i,
    .light_north_south_o,
    .light_south_north_o,
    .light_west_east_o,
    .light_east_west_o
  );

  // Intersection model state
  cnt_t queue_cnt[NumDirs] = '{default: '0};
  cnt_t wait_cnt[NumDirs] = '{default: '0};
  cnt_t hold_left = '0;
  logic ew_green = 1'b0;
  cnt_t wait_limit_cfg = WaitLimitRst;
  cnt_t hold_ticks_cfg = HoldTicksRst;

  arrivals_t cars_pending[$];
  light_t lights_due[$];
  arrivals_t next_tick;
  light_t lights_want;
  light_t lights_got;
  string light_names[NumDirs] = '{"light_north_south", "light_south_north",
                                  "light_west_east", "light_east_west"};

  int unsigned tx_idle_pct = 31;
  int unsigned rx_idle_pct = 48;
  int unsigned failures = 0;
  int unsigned ticks_sent = 0;
  int unsigned lights_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;

  function automatic light_t tick_intersection(input arrivals_t cars);
    logic [ArriveW-1:0] add[NumDirs];
    logic [CntW:0] sum;
    logic [CntW:0] ns_total;
    logic [CntW:0] ew_total;
    logic is_ew;
    light_t lit;
    add[DirNs] = cars.ns;
    add[DirSn] = cars.sn;
    add[DirWe] = cars.we;
    add[DirEw] = cars.ew;
    lit = '0;
    for (int d = 0; d < NumDirs; d++) begin
      sum = (CntW+1)'(queue_cnt[d]) + (CntW+1)'(add[d]);
      queue_cnt[d] = sum[CntW] ? CntMax : sum[CntW-1:0];
    end
    if (hold_left != '0) begin
      hold_left = hold_left - cnt_t'(1);
    end else begin
      ns_total = (CntW+1)'(queue_cnt[DirNs]) + (CntW+1)'(queue_cnt[DirSn]);
      ew_total = (CntW+1)'(queue_cnt[DirWe]) + (CntW+1)'(queue_cnt[DirEw]);
      if (ns_total < ew_total) begin
        ew_green = 1'b1;
      end
      if (ew_green && (wait_cnt[DirNs] > wait_limit_cfg || wait_cnt[DirSn] > wait_limit_cfg)) begin
        hold_left = hold_ticks_cfg;
        ew_green = 1'b0;
        wait_cnt[DirNs] = '0;
        wait_cnt[DirSn] = '0;
      end
      if (!ew_green && (wait_cnt[DirWe] > wait_limit_cfg || wait_cnt[DirEw] > wait_limit_cfg)) begin
        hold_left = hold_ticks_cfg;
        ew_green = 1'b1;
        wait_cnt[DirWe] = '0;
        wait_cnt[DirEw] = '0;
      end
    end
    for (int d = 0; d < NumDirs; d++) begin
      is_ew = (d == DirWe || d == DirEw);
      if (is_ew == ew_green) begin
        lit[d] = (queue_cnt[d] != '0);
      end else if (queue_cnt[d] != '0 && wait_cnt[d] != CntMax) begin
        wait_cnt[d] = wait_cnt[d] + cnt_t'(1);
      end
    end
    for (int d = 0; d < NumDirs; d++) begin
      if (lit[d]) begin
        queue_cnt[d] = queue_cnt[d] - cnt_t'(1);
      end
    end
    return lit;
  endfunction

  function automatic logic [ArriveW-1:0] draw_cars(input int unsigned busy_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < busy_pct) begin
      return ArriveW'($urandom_range(15));
    end
    return ($urandom_range(99) < 15) ? 4'd1 : 4'd0;
  endfunction

  task automatic write_reg(input logic [PaddrW-1:0] addr, input cnt_t value);
    logic [PdataW-1:0] wdata;
    wdata = $urandom();
    wdata[CntW-1:0] = value;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == AddrWaitLimit) begin
      wait_limit_cfg = value;
    end else if (addr == AddrHoldTicks) begin
      hold_ticks_cfg = value;
    end
    reg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CntW-1:0] !== value) begin
      $error("register 0x%0h: expected %0d, got %0d", addr, value, prdata[CntW-1:0]);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (cars_pending.size() != 0 || in_valid_i || lights_due.size() != 0);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: advance to the next tick once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        lights_due.push_back(tick_intersection('{arrive_north_south_i, arrive_south_north_i,
                                                 arrive_west_east_i, arrive_east_west_i}));
        ticks_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cars_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_tick = cars_pending.pop_front();
          in_valid_i <= 1'b1;
          arrive_north_south_i <= next_tick.ns;
          arrive_south_north_i <= next_tick.sn;
          arrive_west_east_i <= next_tick.we;
          arrive_east_west_i <= next_tick.ew;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lights_due.size() == 0) begin
        $error("light item with no tick pending");
        failures++;
      end else begin
        lights_want = lights_due.pop_front();
        lights_got = {light_east_west_o, light_west_east_o, light_south_north_o,
                      light_north_south_o};
        for (int d = 0; d < NumDirs; d++) begin
          if (lights_got[d] !== lights_want[d]) begin
            $error("%s: expected %0b, got %0b", light_names[d], lights_want[d], lights_got[d]);
            failures++;
          end
        end
        lights_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int wl_sched[NumChunks] = '{0, 3, 255, 2, 1, -1, 10, -1, 5};
    int ht_sched[NumChunks] = '{0, 1, 255, 255, 0, -1, 4, -1, 3};
    int unsigned busy_sched[NumChunks] = '{10, 5, 10, 30, 5, 15, 2, 20, 5};
    int unsigned len_sched[NumChunks] = '{120, 120, 320, 120, 120, 120, 140, 120, 145};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle tick, saturating flood, single directions, alternating bits
    cars_pending.push_back('{4'd0, 4'd0, 4'd0, 4'd0});
    repeat (18) cars_pending.push_back('{4'd15, 4'd15, 4'd15, 4'd15});
    cars_pending.push_back('{4'd15, 4'd0, 4'd0, 4'd0});
    cars_pending.push_back('{4'd0, 4'd15, 4'd0, 4'd0});
    cars_pending.push_back('{4'd0, 4'd0, 4'd15, 4'd0});
    cars_pending.push_back('{4'd0, 4'd0, 4'd0, 4'd15});
    cars_pending.push_back('{4'd5, 4'd10, 4'd5, 4'd10});

    for (int c = 0; c < NumChunks; c++) begin
      drain();
      if (c == 3) begin
        tx_idle_pct = 48;
        rx_idle_pct = 31;
      end else if (c == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(AddrWaitLimit, (wl_sched[c] < 0) ? cnt_t'($urandom_range(255)) : cnt_t'(wl_sched[c]));
      write_reg(AddrHoldTicks, (ht_sched[c] < 0) ? cnt_t'($urandom_range(7)) : cnt_t'(ht_sched[c]));
      @(negedge clk_i);
      repeat (len_sched[c]) begin
        cars_pending.push_back('{draw_cars(busy_sched[c]), draw_cars(busy_sched[c]),
                                 draw_cars(busy_sched[c]), draw_cars(busy_sched[c])});
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d ticks across %0d register writes; checked %0d light items.",
             ticks_sent, reg_writes, lights_checked);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tla_pkg.sv
src/traffic_light_arbiter_unit.sv
verif/traffic_light_arbiter_unit_tb.sv
